/* sv/lpgr_pkg.sv */
// Shared types and constants for the LED pixel gap remap block.
// No dependencies; used by every module of the block.
package lpgr_pkg;

   localparam int MAX_GAPS = 16;
   localparam int IDX_W    = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
   localparam int CNT_W    = $clog2(MAX_GAPS + 1);
   localparam int PIX_W    = 16;
   localparam int CMD_W    = 2;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Request command codes.
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD  = 2'd0,
      CMD_L2R  = 2'd1,
      CMD_R2L  = 2'd2,
      CMD_NONE = 2'd3
   } cmd_type;

   // Controller states, one-hot.
   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_WALK = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   // One stored gap, inclusive range.
   typedef struct packed {
      logic [PIX_W-1:0] first;
      logic [PIX_W-1:0] last;
   } gap_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;   // take a new request
      logic step;   // evaluate one gap entry
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic need_walk;  // the offered request must walk the table
      logic walk_last;  // the entry under evaluation ends the walk
   } ctrl_stat_type;

   // Register index for the configuration port.
   localparam logic REG_PIXEL_COUNT = 1'b0;

endpackage

/* sv/lpgr_ctrl.sv */
// Controller state machine for the LED pixel gap remap block.
// Depends on lpgr_pkg; drives the datapath through command and status structs.
module lpgr_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  lpgr_pkg::ctrl_stat_type stat,
   output lpgr_pkg::ctrl_cmd_type  cmd,
   output logic                   busy,
   output logic                   rsp_valid
);

   lpgr_pkg::state_type state_ff;
   lpgr_pkg::state_type state_in;

   always_comb begin
      busy      = (state_ff == lpgr_pkg::ST_WALK);
      rsp_valid = (state_ff == lpgr_pkg::ST_DONE);
      cmd.load  = start && !busy;
      cmd.step  = busy;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpgr_pkg::ST_IDLE, lpgr_pkg::ST_DONE: begin
            if (cmd.load) begin
               state_in = stat.need_walk ? lpgr_pkg::ST_WALK : lpgr_pkg::ST_DONE;
            end else begin
               state_in = lpgr_pkg::ST_IDLE;
            end
         end
         lpgr_pkg::ST_WALK: begin
            if (stat.walk_last) begin
               state_in = lpgr_pkg::ST_DONE;
            end
         end
         default: begin
            state_in = lpgr_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpgr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* sv/lpgr_dp.sv */
// Datapath for the LED pixel gap remap block: gap memory, counters and translator.
// Depends on lpgr_pkg; sequenced by lpgr_ctrl.
module lpgr_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  lpgr_pkg::ctrl_cmd_type         cmd,
   output lpgr_pkg::ctrl_stat_type        stat,
   input  logic [lpgr_pkg::CMD_W-1:0]     req_cmd,
   input  logic [lpgr_pkg::PIX_W-1:0]     req_pixel_a,
   input  logic [lpgr_pkg::PIX_W-1:0]     req_pixel_b,
   input  logic                           cfg_we,
   input  logic [lpgr_pkg::PIX_W-1:0]     cfg_data,
   output logic [lpgr_pkg::PIX_W-1:0]     pixel_count,
   output logic [lpgr_pkg::PIX_W-1:0]     rsp_pixel,
   output logic                           rsp_in_gap,
   output logic [lpgr_pkg::PIX_W-1:0]     rsp_real_count,
   output logic                           rsp_table_full
);

   localparam int PW = lpgr_pkg::PIX_W;

   lpgr_pkg::gap_entry_type gap_mem [lpgr_pkg::MAX_GAPS];
   lpgr_pkg::gap_entry_type rd_data_ff;

   logic [lpgr_pkg::CNT_W-1:0] used_ff, used_in;
   logic [PW-1:0]              total_ff, total_in;
   logic [PW-1:0]              pcount_ff;
   logic [lpgr_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic [lpgr_pkg::CNT_W-1:0] eval_ff, eval_in;
   lpgr_pkg::cmd_type          op_ff;
   logic [PW-1:0]              a_ff;
   logic [PW-1:0]              v_ff, v_in;
   logic                       gap_ff, gap_in;
   logic                       full_ff, full_in;

   lpgr_pkg::cmd_type          req_op;
   logic                       is_full;
   logic                       do_write;
   logic [PW-1:0]              req_span;
   logic [PW-1:0]              span;
   logic                       above_end;
   logic                       at_start;
   logic                       stop;
   logic                       last;
   logic [lpgr_pkg::CNT_W-1:0] eval_next;

   always_comb begin
      req_op    = lpgr_pkg::cmd_type'(req_cmd);
      is_full   = (used_ff == lpgr_pkg::CNT_W'(lpgr_pkg::MAX_GAPS));
      do_write  = cmd.load && (req_op == lpgr_pkg::CMD_ADD) && !is_full;
      req_span  = req_pixel_b - req_pixel_a + PW'(1);
      span      = rd_data_ff.last - rd_data_ff.first + PW'(1);
      above_end = (a_ff > rd_data_ff.last);
      at_start  = (a_ff >= rd_data_ff.first);
      stop      = (op_ff == lpgr_pkg::CMD_L2R) && !above_end && at_start;
      eval_next = eval_ff + lpgr_pkg::CNT_W'(1);
      last      = (eval_next == used_ff);

      stat.need_walk = ((req_op == lpgr_pkg::CMD_L2R) || (req_op == lpgr_pkg::CMD_R2L))
                       && (used_ff != '0);
      stat.walk_last = last || stop;
   end

   always_comb begin
      used_in   = used_ff;
      total_in  = total_ff;
      rd_idx_in = rd_idx_ff;
      eval_in   = eval_ff;
      v_in      = v_ff;
      gap_in    = gap_ff;
      full_in   = full_ff;
      if (cmd.load) begin
         v_in      = req_pixel_a;
         gap_in    = 1'b0;
         full_in   = (req_op == lpgr_pkg::CMD_ADD) && is_full;
         eval_in   = '0;
         rd_idx_in = lpgr_pkg::IDX_W'(1);
         if (do_write) begin
            used_in  = used_ff + lpgr_pkg::CNT_W'(1);
            total_in = total_ff + req_span;
         end
         if (!stat.need_walk) begin
            rd_idx_in = '0;
         end
      end else if (cmd.step) begin
         eval_in   = eval_next;
         rd_idx_in = rd_idx_ff + lpgr_pkg::IDX_W'(1);
         if (op_ff == lpgr_pkg::CMD_L2R) begin
            if (above_end) begin
               v_in = v_ff - span;
            end else if (at_start) begin
               gap_in = 1'b1;
            end
         end else if (v_ff >= rd_data_ff.first) begin
            v_in = v_ff + span;
         end
         if (stat.walk_last) begin
            rd_idx_in = '0;
         end
      end
   end

   // Gap memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (do_write) begin
         gap_mem[used_ff[lpgr_pkg::IDX_W-1:0]] <= '{first: req_pixel_a, last: req_pixel_b};
      end
      rd_data_ff <= gap_mem[rd_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff   <= '0;
         total_ff  <= '0;
         pcount_ff <= '0;
         rd_idx_ff <= '0;
         eval_ff   <= '0;
         gap_ff    <= 1'b0;
         full_ff   <= 1'b0;
      end else begin
         used_ff   <= used_in;
         total_ff  <= total_in;
         rd_idx_ff <= rd_idx_in;
         eval_ff   <= eval_in;
         gap_ff    <= gap_in;
         full_ff   <= full_in;
         if (cfg_we) begin
            pcount_ff <= cfg_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff <= req_op;
         a_ff  <= req_pixel_a;
      end
      v_ff <= v_in;
   end

   always_comb begin
      pixel_count    = pcount_ff;
      rsp_real_count = pcount_ff - total_ff;
      rsp_in_gap     = gap_ff;
      rsp_table_full = full_ff;
      if (((op_ff == lpgr_pkg::CMD_L2R) && !gap_ff) || (op_ff == lpgr_pkg::CMD_R2L)) begin
         rsp_pixel = v_ff;
      end else begin
         rsp_pixel = '0;
      end
   end

endmodule

/* sv/led_pixel_gap_remap.sv */
// LED pixel gap remap, top level: configuration port, controller and datapath.
// Adds and unused commands answer the cycle after acceptance; translations first walk
// the gap entries one per cycle (all stored gaps, or fewer when a logical pixel lands in a
// gap), then answer. Busy is high during that walk only. No request is taken during a walk;
// the next one may be taken in the result cycle, and the receiver cannot stall. Reset
// empties the table, clears gap total and pixel_count.
module led_pixel_gap_remap (
   input  logic                            clock,
   input  logic                            reset,
   // Request channel.
   input  logic                            start,
   output logic                            busy,
   input  logic [lpgr_pkg::CMD_W-1:0]      req_cmd,
   input  logic [lpgr_pkg::PIX_W-1:0]      req_pixel_a,
   input  logic [lpgr_pkg::PIX_W-1:0]      req_pixel_b,
   // Result channel; the receiver takes every strobed result.
   output logic                            rsp_valid,
   output logic [lpgr_pkg::PIX_W-1:0]      rsp_pixel,
   output logic                            rsp_in_gap,
   output logic [lpgr_pkg::PIX_W-1:0]      rsp_real_count,
   output logic                            rsp_table_full,
   // Configuration port.
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [lpgr_pkg::CSR_AW-1:0]     paddr,
   input  logic [lpgr_pkg::CSR_DW-1:0]     pwdata,
   output logic [lpgr_pkg::CSR_DW-1:0]     prdata,
   output logic                            pready
);

   lpgr_pkg::ctrl_cmd_type  ctl_cmd;
   lpgr_pkg::ctrl_stat_type ctl_stat;
   logic                    cfg_we;
   logic [lpgr_pkg::PIX_W-1:0] pixel_count;

   // The only register is pixel_count at byte address zero. Address bit 2 selects
   // the register index; anything beyond the first register reads as zero and
   // ignores writes.
   always_comb begin
      pready = 1'b1;
      cfg_we = psel && penable && pwrite && pready
               && (paddr[2] == lpgr_pkg::REG_PIXEL_COUNT);
      if (paddr[2] == lpgr_pkg::REG_PIXEL_COUNT) begin
         prdata = {{(lpgr_pkg::CSR_DW - lpgr_pkg::PIX_W){1'b0}}, pixel_count};
      end else begin
         prdata = '0;
      end
   end

   // The controller sequences one request at a time: a translation walks the gap
   // table in insertion order, one entry per cycle, then shows the result for a
   // single cycle. A new request may be taken in that result cycle.
   lpgr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .stat      (ctl_stat),
      .cmd       (ctl_cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   // The datapath holds the gap memory, the fill count, the running gap total and
   // the translation accumulator.
   lpgr_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (ctl_cmd),
      .stat           (ctl_stat),
      .req_cmd        (req_cmd),
      .req_pixel_a    (req_pixel_a),
      .req_pixel_b    (req_pixel_b),
      .cfg_we         (cfg_we),
      .cfg_data       (pwdata[lpgr_pkg::PIX_W-1:0]),
      .pixel_count    (pixel_count),
      .rsp_pixel      (rsp_pixel),
      .rsp_in_gap     (rsp_in_gap),
      .rsp_real_count (rsp_real_count),
      .rsp_table_full (rsp_table_full)
   );

endmodule

/* sv/lpgr_checker.sv */
// Port-level checks for the LED pixel gap remap block.
// Depends on lpgr_pkg; bound to led_pixel_gap_remap below.
module lpgr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        start,
   input logic                        busy,
   input logic [lpgr_pkg::CMD_W-1:0]  req_cmd,
   input logic                        rsp_valid,
   input logic [lpgr_pkg::PIX_W-1:0]  rsp_pixel,
   input logic                        rsp_in_gap,
   input logic                        rsp_table_full
);

   // A result is never shown while a walk is still running.
   a_valid_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result strobe while busy");

   // Adds and unused commands answer in the next cycle.
   a_short_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && ((req_cmd == lpgr_pkg::CMD_ADD) || (req_cmd == lpgr_pkg::CMD_NONE)))
      |=> rsp_valid)
      else $error("add or unused command did not answer in one cycle");

   // An accepted request either walks or answers at once.
   a_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_valid))
      else $error("accepted request neither walking nor answered");

   // A pixel inside a gap translates to zero, and never with a refused add.
   a_gap_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_in_gap) |-> ((rsp_pixel == '0) && !rsp_table_full))
      else $error("in_gap result carries a pixel or table_full");

endmodule

bind led_pixel_gap_remap lpgr_checker u_lpgr_checker (
   .clock          (clock),
   .reset          (reset),
   .start          (start),
   .busy           (busy),
   .req_cmd        (req_cmd),
   .rsp_valid      (rsp_valid),
   .rsp_pixel      (rsp_pixel),
   .rsp_in_gap     (rsp_in_gap),
   .rsp_table_full (rsp_table_full)
);
